/* rtl/hilb_pkg.sv */
// ----------------------------------------------------------------------------
// hilb_pkg - shared constants for the Hilbert index to grid mapper
// Field widths, pipeline partitioning and the per-level quadrant codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hilb_pkg;

   // default deepest curve order supported by the pipeline
   localparam int DEFAULT_MAX_ORDER = 16;

   // recursion levels evaluated between two pipeline registers
   localparam int LEVELS_PER_STAGE = 4;

   // never fewer register stages than this
   localparam int MIN_STAGES = 3;

   localparam int CSR_WIDTH   = 5;
   localparam int INDEX_WIDTH = 32;
   localparam int COORD_WIDTH = 16;

   // quadrant codes taken from one pair of index bits
   localparam logic [1:0] QUAD_SWAP    = 2'd0;
   localparam logic [1:0] QUAD_UP      = 2'd1;
   localparam logic [1:0] QUAD_DIAG    = 2'd2;
   localparam logic [1:0] QUAD_REFLECT = 2'd3;

endpackage : hilb_pkg

`default_nettype wire

/* rtl/hilb_stage.sv */
// ----------------------------------------------------------------------------
// hilb_stage - one register stage of the Hilbert mapping pipeline
// Applies up to LEVELS_PER_STAGE recursion levels starting at FIRST_LEVEL,
// then registers the point together with its valid bit.
// ----------------------------------------------------------------------------
`default_nettype none

module hilb_stage
   import hilb_pkg::*;
#(
   parameter int MAX_ORDER   = DEFAULT_MAX_ORDER,
   parameter int FIRST_LEVEL = 0,
   parameter int CW          = MAX_ORDER,
   parameter int IW          = 2 * MAX_ORDER,
   parameter int OW          = $clog2(MAX_ORDER + 1)
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   output logic               in_ready,
   input  wire logic [CW-1:0] in_x,
   input  wire logic [CW-1:0] in_y,
   input  wire logic [IW-1:0] in_idx,
   input  wire logic [OW-1:0] in_ord,
   output logic               out_valid,
   input  wire logic          out_ready,
   output logic [CW-1:0]      out_x,
   output logic [CW-1:0]      out_y,
   output logic [IW-1:0]      out_idx,
   output logic [OW-1:0]      out_ord
);

   logic          valid_ff;
   logic [CW-1:0] x_ff, y_ff;
   logic [IW-1:0] idx_ff;
   logic [OW-1:0] ord_ff;
   logic [CW-1:0] x_in, y_in;
   logic          load;

   logic [CW-1:0] xs [LEVELS_PER_STAGE+1];
   logic [CW-1:0] ys [LEVELS_PER_STAGE+1];

   assign xs[0] = in_x;
   assign ys[0] = in_y;

   for (genvar j = 0; j < LEVELS_PER_STAGE; j++) begin : g_level
      localparam int L = FIRST_LEVEL + j;
      if (L == 0) begin : g_base
         // U pattern: (0,0) (0,1) (1,1) (1,0)
         assign xs[j+1] = CW'(in_idx[1]);
         assign ys[j+1] = CW'(in_idx[1] ^ in_idx[0]);
      end else if (L < MAX_ORDER) begin : g_step
         localparam logic [CW-1:0] HALF = CW'(1) << L;
         localparam logic [CW-1:0] LOW  = HALF - CW'(1);
         logic [1:0] quad;
         assign quad = in_idx[2*L+1 -: 2];
         always_comb begin
            xs[j+1] = xs[j];
            ys[j+1] = ys[j];
            if (in_ord > OW'(L)) begin
               unique case (quad)
                  QUAD_SWAP: begin
                     xs[j+1] = ys[j];
                     ys[j+1] = xs[j];
                  end
                  QUAD_UP: begin
                     ys[j+1] = ys[j] | HALF;
                  end
                  QUAD_DIAG: begin
                     xs[j+1] = xs[j] | HALF;
                     ys[j+1] = ys[j] | HALF;
                  end
                  QUAD_REFLECT: begin
                     // point sits below HALF, so half-1-v is a masked complement
                     xs[j+1] = (~ys[j] & LOW) | HALF;
                     ys[j+1] = ~xs[j] & LOW;
                  end
               endcase
            end
         end
      end else begin : g_pass
         assign xs[j+1] = xs[j];
         assign ys[j+1] = ys[j];
      end
   end

   assign x_in = xs[LEVELS_PER_STAGE];
   assign y_in = ys[LEVELS_PER_STAGE];

   assign in_ready = !valid_ff || out_ready;
   assign load     = in_valid && in_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         idx_ff <= in_idx;
         ord_ff <= in_ord;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_idx   = idx_ff;
   assign out_ord   = ord_ff;

endmodule : hilb_stage

`default_nettype wire

/* rtl/hilbert_index_to_xy.sv */
// ----------------------------------------------------------------------------
// hilbert_index_to_xy - Hilbert curve position to grid cell
// Pipelined mapping of a curve index to (x, y) for a programmable order.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_curve_index[31:0]
//   rsp      out        rsp_valid/rsp_stall  rsp_grid_x[15:0], rsp_grid_y[15:0]
//   csr      in         csr_wr_en            csr_wr_data[4:0] (curve order)
//
// One index accepted per cycle while rsp is not stalled; NUM_STAGES register
// stages, four recursion levels per stage (4 stages when MAX_ORDER is 16).
// Synchronous reset empties the pipeline and sets the order to 1; inputs
// are stalled while reset is high.
// A stall on rsp backs up stage by stage; bubbles are squeezed out.
// ----------------------------------------------------------------------------
`default_nettype none

module hilbert_index_to_xy
   import hilb_pkg::*;
#(
   parameter int MAX_ORDER = DEFAULT_MAX_ORDER
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [INDEX_WIDTH-1:0] req_curve_index,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [COORD_WIDTH-1:0]      rsp_grid_x,
   output logic [COORD_WIDTH-1:0]      rsp_grid_y,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_WIDTH-1:0]   csr_wr_data
);

   localparam int CW = MAX_ORDER;
   localparam int IW = 2 * MAX_ORDER;
   localparam int OW = $clog2(MAX_ORDER + 1);
   localparam int STAGES_NEEDED = (MAX_ORDER + LEVELS_PER_STAGE - 1) / LEVELS_PER_STAGE;
   localparam int NUM_STAGES = (STAGES_NEEDED > MIN_STAGES) ? STAGES_NEEDED : MIN_STAGES;

   // effective order, clamped at write time
   logic [OW-1:0] ord_ff, ord_in;

   always_comb begin
      priority if (csr_wr_data == '0) begin
         ord_in = OW'(1);
      end else if ({1'b0, csr_wr_data} > (CSR_WIDTH+1)'(MAX_ORDER)) begin
         ord_in = OW'(MAX_ORDER);
      end else begin
         ord_in = OW'(csr_wr_data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ord_ff <= OW'(1);
      end else if (csr_wr_en) begin
         ord_ff <= ord_in;
      end
   end

   logic          v   [NUM_STAGES+1];
   logic          rdy [NUM_STAGES+1];
   logic [CW-1:0] px  [NUM_STAGES+1];
   logic [CW-1:0] py  [NUM_STAGES+1];
   logic [IW-1:0] pidx[NUM_STAGES+1];
   logic [OW-1:0] pord[NUM_STAGES+1];
   logic [NUM_STAGES-1:0] valid_vec;

   assign v[0]    = req_valid && !reset;
   assign px[0]   = '0;
   assign py[0]   = '0;
   assign pidx[0] = IW'({{IW{1'b0}}, req_curve_index});
   assign pord[0] = ord_ff;

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
      hilb_stage #(
         .MAX_ORDER   (MAX_ORDER),
         .FIRST_LEVEL (s * LEVELS_PER_STAGE),
         .CW          (CW),
         .IW          (IW),
         .OW          (OW)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v[s]),
         .in_ready  (rdy[s]),
         .in_x      (px[s]),
         .in_y      (py[s]),
         .in_idx    (pidx[s]),
         .in_ord    (pord[s]),
         .out_valid (v[s+1]),
         .out_ready (rdy[s+1]),
         .out_x     (px[s+1]),
         .out_y     (py[s+1]),
         .out_idx   (pidx[s+1]),
         .out_ord   (pord[s+1])
      );
      assign valid_vec[s] = v[s+1];
   end

   assign rdy[NUM_STAGES] = !rsp_stall;
   assign req_stall       = reset || !rdy[0];

   assign rsp_valid  = v[NUM_STAGES];
   assign rsp_grid_x = COORD_WIDTH'({{COORD_WIDTH{1'b0}}, px[NUM_STAGES]});
   assign rsp_grid_y = COORD_WIDTH'({{COORD_WIDTH{1'b0}}, py[NUM_STAGES]});

   // ---- assertions ----
   logic req_xfer, rsp_xfer;
   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   // occupancy rises by one when a transfer enters and none leaves
   a_occ_up: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !rsp_xfer) |=>
         $countones(valid_vec) == $past($countones(valid_vec)) + 1)
      else $error("pipeline lost or invented an item on entry");

   // occupancy falls by one when a transfer leaves and none enters
   a_occ_down: assert property (@(posedge clock) disable iff (reset)
      (!req_xfer && rsp_xfer) |=>
         $countones(valid_vec) == $past($countones(valid_vec)) - 1)
      else $error("pipeline lost or repeated an item on exit");

   // occupancy holds when transfers balance
   a_occ_hold: assert property (@(posedge clock) disable iff (reset)
      (req_xfer == rsp_xfer) |=> $countones(valid_vec) == $past($countones(valid_vec)))
      else $error("pipeline occupancy changed without a transfer");

   // a free output never backs up into the input
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output is free");

endmodule : hilbert_index_to_xy

`default_nettype wire

/* sim/hilbert_index_to_xy_tb.sv */
// ----------------------------------------------------------------------------
// hilbert_index_to_xy_tb - self-checking bench for the Hilbert index mapper
// Streams curve indices through the block under several curve orders and
// traffic patterns, and compares each grid cell with a local Hilbert model.
// ----------------------------------------------------------------------------
module hilbert_index_to_xy_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hilb_pkg::*;

   localparam int MAX_ORDER    = DEFAULT_MAX_ORDER;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 150;
   localparam int NUM_PHASES   = 13;
   localparam int DRAIN_CYCLES = 12;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] index;
      logic [COORD_WIDTH-1:0] x;
      logic [COORD_WIDTH-1:0] y;
   } grid_point_type;

   class hilbert_scoreboard;
      logic [CSR_WIDTH-1:0] curve_order_q;
      grid_point_type       expected_cells[$];
      int                   failures;

      function new();
         curve_order_q = 5'd1;
         failures      = 0;
      endfunction

      function void set_order(input logic [CSR_WIDTH-1:0] value);
         curve_order_q = value;
      endfunction

      // walk the curve from the base U cell outwards, one level per index pair
      function grid_point_type map_index(input logic [INDEX_WIDTH-1:0] index);
         int unsigned            levels;
         logic [INDEX_WIDTH-1:0] bits;
         logic [31:0]            x, y, t, half;
         grid_point_type         point;
         levels = curve_order_q;
         if (levels < 1) levels = 1;
         if (levels > MAX_ORDER) levels = MAX_ORDER;
         bits = index;
         x = {31'd0, bits[1]};
         y = {31'd0, bits[1] ^ bits[0]};
         bits = bits >> 2;
         for (int unsigned lvl = 1; lvl < levels; lvl++) begin
            half = 32'd1 << lvl;
            case (bits[1:0])
               QUAD_SWAP: begin
                  t = x;
                  x = y;
                  y = t;
               end
               QUAD_UP: begin
                  y = y + half;
               end
               QUAD_DIAG: begin
                  x = x + half;
                  y = y + half;
               end
               default: begin
                  // anti-diagonal reflection, then shift right by half
                  t = y;
                  y = half - 1 - x;
                  x = half - 1 - t + half;
               end
            endcase
            bits = bits >> 2;
         end
         point.index = index;
         point.x     = x[COORD_WIDTH-1:0];
         point.y     = y[COORD_WIDTH-1:0];
         return point;
      endfunction

      function void note_index(input logic [INDEX_WIDTH-1:0] index);
         expected_cells.insert(expected_cells.size(), map_index(index));
      endfunction

      function void check_cell(input logic [COORD_WIDTH-1:0] x,
                               input logic [COORD_WIDTH-1:0] y);
         grid_point_type exp_cell;
         if (expected_cells.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected transfer on rsp: x %0d y %0d", x, y);
            return;
         end
         exp_cell = expected_cells.pop_front();
         if (x !== exp_cell.x || y !== exp_cell.y) begin
            failures++;
            if (failures <= 10)
               $display("mismatch index %h order %0d: x exp %0d got %0d, y exp %0d got %0d",
                        exp_cell.index, curve_order_q, exp_cell.x, x, exp_cell.y, y);
         end
      endfunction

      function int outstanding();
         return expected_cells.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [INDEX_WIDTH-1:0] req_curve_index = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [COORD_WIDTH-1:0] rsp_grid_x;
   logic [COORD_WIDTH-1:0] rsp_grid_y;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_WIDTH-1:0]   csr_wr_data = '0;

   int                     idle_pct  = 0;
   int                     stall_pct = 0;
   int                     cycle_count = 0;
   hilbert_scoreboard      sb = new();

   hilbert_index_to_xy #(
      .MAX_ORDER(MAX_ORDER)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_curve_index(req_curve_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_grid_x     (rsp_grid_x),
      .rsp_grid_y     (rsp_grid_y),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_cell(rsp_grid_x, rsp_grid_y);
   end

   // one transfer on req, with random idle cycles ahead of it
   task automatic send_index(input logic [INDEX_WIDTH-1:0] index);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_curve_index <= index;
      do @(posedge clock); while (req_stall);
      sb.note_index(index);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(input logic [CSR_WIDTH-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_order(value);
   endtask

   initial begin
      logic [CSR_WIDTH-1:0]   phase_orders[NUM_PHASES];
      logic [INDEX_WIDTH-1:0] index;
      phase_orders = '{5'd0, 5'd16, 5'd31, 5'd17, 5'd2, 5'd3, 5'd7,
                       5'd8, 5'd9, 5'd12, 5'd15, 5'd1, 5'd16};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset order: only the base U cell, upper bits ignored
      send_index(32'h0000_0000);
      send_index(32'h0000_0001);
      send_index(32'h0000_0002);
      send_index(32'h0000_0003);
      send_index(32'hFFFF_FFFC);
      send_index(32'hFFFF_FFFF);
      wait_drained();

      // deepest order: every quadrant code at low and high levels
      write_order(5'd16);
      send_index(32'h0000_0000);
      send_index(32'hFFFF_FFFF);
      send_index(32'h5555_5555);
      send_index(32'hAAAA_AAAA);
      send_index(32'h0000_0004);
      send_index(32'h0000_0008);
      send_index(32'h0000_000C);
      send_index(32'h4000_0000);
      send_index(32'h8000_0000);
      send_index(32'hC000_0000);
      send_index(32'h3333_3333);
      send_index(32'hCCCC_CCCC);
      send_index(32'h0000_FFFF);
      send_index(32'hFFFF_0000);
      wait_drained();

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_order((p == 6) ? 5'($urandom_range(31)) : phase_orders[p]);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 74; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 74; end
            default: begin idle_pct = 22; stall_pct = 22; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            index = $urandom();
            send_index(index);
         end
         wait_drained();
         idle_pct  = 0;
         stall_pct = 0;
      end

      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule : hilbert_index_to_xy_tb

/* sim.f */
rtl/hilb_pkg.sv
rtl/hilb_stage.sv
rtl/hilbert_index_to_xy.sv
sim/hilbert_index_to_xy_tb.sv
